>>> rtl/four_point_square_test_core_macros.svh
// Assertion helpers for the four point square check core.
`ifndef FOUR_POINT_SQUARE_TEST_CORE_MACROS_SVH
`define FOUR_POINT_SQUARE_TEST_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FPSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication whose consequent must hold in the cycle after its antecedent.
`define FPSQ_ASSERT_NEXT(lbl, pre, post, msg) \
  `FPSQ_ASSERT(lbl, (pre) |=> (post), msg)

`endif

>>> rtl/fpsq_pkg.sv
package fpsq_pkg;

  // Default coordinate width in bits.
  localparam int unsigned CoordWidthDefault = 16;

  // Four points give six distinct pairs.
  localparam int unsigned NumPoints = 4;
  localparam int unsigned NumPairs  = 6;

  // Register stages from input to result.
  localparam int unsigned NumStages = 6;

  // Result word: is_square in bit 0, padded to one byte.
  localparam int unsigned OutTdataWidth = 8;

  typedef logic [1:0] pt_idx_t;

  // Point indices of each pair: ab, ac, ad, bc, bd, cd.
  localparam pt_idx_t PairA [NumPairs] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam pt_idx_t PairB [NumPairs] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

endpackage

>>> rtl/four_point_square_test_core.sv
// Four point square check. Each input word carries four integer points
// (x and y per point, COORD_WIDTH-bit two's complement); the result word says
// whether those points are the corners of a nondegenerate square, in any
// order. The test is exact: the six squared pair distances must show four
// equal nonzero sides and two diagonals of twice that value; coincident points
// give 0. The core is a six-stage pipeline (difference, square, sum, two min
// stages, compare/count): one word enters every cycle unless the pipeline is
// full and the output stalled, and a stalled output backs up the pipeline
// stage by stage, with empty stages filled while it waits.
module four_point_square_test_core #(
  parameter int unsigned COORD_WIDTH = fpsq_pkg::CoordWidthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // ax, ay, bx, by, cx, cy, dx, dy from bit 0 up, COORD_WIDTH bits each
  input  logic [8*COORD_WIDTH-1:0]             s_axis_tdata,
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // is_square in bit 0, remaining bits zero
  output logic [fpsq_pkg::OutTdataWidth-1:0]   m_axis_tdata
);

  import fpsq_pkg::*;

  localparam int unsigned SqWidth   = 2 * COORD_WIDTH;
  localparam int unsigned DistWidth = 2 * COORD_WIDTH + 1;
  localparam int unsigned Last      = NumStages - 1;

  // Stage enables and valid bits
  logic [NumStages-1:0] en;
  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] v_in;

  // Load a stage when it is empty or its content moves on
  always_comb begin
    en[Last] = !v_q[Last] || m_axis_tready;
    for (int k = Last - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in          = {v_q[Last-1:0], s_axis_tvalid};
  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 0: absolute coordinate differences per pair
  logic [COORD_WIDTH-1:0] px [NumPoints];
  logic [COORD_WIDTH-1:0] py [NumPoints];
  logic [COORD_WIDTH:0]   dxw [NumPairs];
  logic [COORD_WIDTH:0]   dyw [NumPairs];
  logic [COORD_WIDTH:0]   axw [NumPairs];
  logic [COORD_WIDTH:0]   ayw [NumPairs];
  logic [COORD_WIDTH-1:0] ux_q [NumPairs];
  logic [COORD_WIDTH-1:0] uy_q [NumPairs];

  always_comb begin
    for (int i = 0; i < NumPoints; i++) begin
      px[i] = s_axis_tdata[(2*i)*COORD_WIDTH +: COORD_WIDTH];
      py[i] = s_axis_tdata[(2*i+1)*COORD_WIDTH +: COORD_WIDTH];
    end
    for (int p = 0; p < NumPairs; p++) begin
      dxw[p] = {px[PairA[p]][COORD_WIDTH-1], px[PairA[p]]}
             - {px[PairB[p]][COORD_WIDTH-1], px[PairB[p]]};
      dyw[p] = {py[PairA[p]][COORD_WIDTH-1], py[PairA[p]]}
             - {py[PairB[p]][COORD_WIDTH-1], py[PairB[p]]};
      axw[p] = dxw[p][COORD_WIDTH] ? ((COORD_WIDTH+1)'(0) - dxw[p]) : dxw[p];
      ayw[p] = dyw[p][COORD_WIDTH] ? ((COORD_WIDTH+1)'(0) - dyw[p]) : dyw[p];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int p = 0; p < NumPairs; p++) begin
        ux_q[p] <= axw[p][COORD_WIDTH-1:0];
        uy_q[p] <= ayw[p][COORD_WIDTH-1:0];
      end
    end
  end

  // Stage 1: square each difference
  logic [SqWidth-1:0] sx_q [NumPairs];
  logic [SqWidth-1:0] sy_q [NumPairs];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int p = 0; p < NumPairs; p++) begin
        sx_q[p] <= SqWidth'(ux_q[p]) * SqWidth'(ux_q[p]);
        sy_q[p] <= SqWidth'(uy_q[p]) * SqWidth'(uy_q[p]);
      end
    end
  end

  // Stage 2: squared distance per pair
  logic [DistWidth-1:0] d2_q [NumPairs];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int p = 0; p < NumPairs; p++) begin
        d2_q[p] <= DistWidth'(sx_q[p]) + DistWidth'(sy_q[p]);
      end
    end
  end

  // Stage 3: minimum of each neighboring pair of distances
  logic [DistWidth-1:0] d3_q [NumPairs];
  logic [DistWidth-1:0] m3_q [NumPairs/2];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int p = 0; p < NumPairs; p++) begin
        d3_q[p] <= d2_q[p];
      end
      for (int h = 0; h < NumPairs / 2; h++) begin
        m3_q[h] <= (d2_q[2*h+1] < d2_q[2*h]) ? d2_q[2*h+1] : d2_q[2*h];
      end
    end
  end

  // Stage 4: overall smallest distance
  logic [DistWidth-1:0] m01;
  logic [DistWidth-1:0] s4_d;
  logic [DistWidth-1:0] d4_q [NumPairs];
  logic [DistWidth-1:0] s4_q;

  always_comb begin
    m01  = (m3_q[1] < m3_q[0]) ? m3_q[1] : m3_q[0];
    s4_d = (m3_q[2] < m01) ? m3_q[2] : m01;
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int p = 0; p < NumPairs; p++) begin
        d4_q[p] <= d3_q[p];
      end
      s4_q <= s4_d;
    end
  end

  // Stage 5: count sides and diagonals, decide
  logic [DistWidth:0]   twice_s;
  logic [NumPairs-1:0]  is_side;
  logic [NumPairs-1:0]  is_diag;
  logic [2:0]           n_side;
  logic [2:0]           n_diag;
  logic                 sq_d;
  logic                 sq_q;

  always_comb begin
    twice_s = {s4_q, 1'b0};
    n_side  = '0;
    n_diag  = '0;
    for (int p = 0; p < NumPairs; p++) begin
      is_side[p] = (d4_q[p] == s4_q);
      is_diag[p] = !is_side[p] && ({1'b0, d4_q[p]} == twice_s);
      n_side     = n_side + 3'(is_side[p]);
      n_diag     = n_diag + 3'(is_diag[p]);
    end
    sq_d = (|s4_q) && (n_side == 3'd4) && (n_diag == 3'd2);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      sq_q <= sq_d;
    end
  end

  // Drive the result word
  assign m_axis_tvalid = v_q[Last];
  assign m_axis_tdata  = {(OutTdataWidth-1)'(0), sq_q};

  // Checks
`include "four_point_square_test_core_macros.svh"

  `FPSQ_ASSERT_NEXT(a_accept_fills, s_axis_tvalid && s_axis_tready, v_q[0], "accepted word lost at stage 0")
  `FPSQ_ASSERT(a_full_blocks, ((&v_q) && !m_axis_tready) |-> !s_axis_tready, "word accepted into full pipeline")
  `FPSQ_ASSERT_NEXT(a_bubble_moves, !v_q[Last-1] && en[Last], !v_q[Last], "result without source word")
  `FPSQ_ASSERT_NEXT(a_stall_holds, v_q[Last] && !m_axis_tready, v_q[Last] && $stable(sq_q), "stalled result changed")

endmodule
